// ----- src/aesbe_pkg.sv -----
// ----------------------------------------------------------------------------
// AES block encryption package
// Shared constants and GF(2^8) helper functions.
// ----------------------------------------------------------------------------
package aesbe_pkg;

   localparam int DefaultRounds        = 10;
   localparam int DefaultScheduleWords = 44;

   localparam logic ACT_KEY_WRITE = 1'b0;
   localparam logic ACT_ENCRYPT   = 1'b1;

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] x;
      acc = 8'h00;
      x   = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            acc = acc ^ x;
         end
         x = xtime(x);
      end
      gf_mul = acc;
   endfunction

   // Standard AES forward S-box as a constant table.
   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

endpackage

// ----- src/aes_block_encrypt_top.sv -----
// ----------------------------------------------------------------------------
// AES block encryption top level
// Column-serial AES-128/192/256 cipher core with a loadable key schedule.
// ----------------------------------------------------------------------------
// Channel | Dir | Ports                         | Word contents
// req     | in  | req_tvalid/tready/tdata/tuser | tuser: action; tdata: key/block
// rsp     | out | rsp_tvalid/tready/tdata       | tdata: ciphertext
//
// The state is held as four 32-bit columns in a shift register. One column
// (one digit) passes through SubBytes, MixColumns and AddRoundKey per cycle,
// unless the last column is held; the single column datapath and the one
// schedule word read per cycle from the key store set this rate.
// After an encryption word is accepted, ST_PRIME primes the key read, then
// ST_RUN handles the initial key addition (AddRoundKey only) and each
// round column by column, the final round without MixColumns; rsp_tvalid
// rises as the last column is written. A new word is accepted only once
// the core is back in idle. A key write leaves the core idle and ready.
// Reset clears only control state; the key store is not cleared.
// A result waits in its output register while rsp_tready is low; new words
// are still accepted, and an encryption that reaches its last column while
// the register is still full holds that column until the register is taken.
module aes_block_encrypt_top
   import aesbe_pkg::*;
#(
   parameter int ROUNDS         = DefaultRounds,
   parameter int SCHEDULE_WORDS = DefaultScheduleWords
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata, lowest bit up: key_index[5:0], key_word[37:6],
   // block_high[101:38], block_low[165:102], zeros[167:166]
   input  logic [167:0] req_tdata,
   // tuser: action[0]
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata, lowest bit up: cipher_high[63:0], cipher_low[127:64]
   output logic [127:0] rsp_tdata
);

   localparam int AddrW  = $clog2(SCHEDULE_WORDS);
   localparam int RoundW = $clog2(ROUNDS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PRIME,
      ST_RUN
   } state_type;

   state_type           state_ff;
   logic [RoundW-1:0]   round_ff;
   logic [1:0]          col_ff;
   logic [31:0]         cols_ff [4];
   logic                rsp_valid_ff;
   logic [127:0]        rsp_data_ff;
   logic [RoundW+1:0]   rd_idx;
   logic [AddrW-1:0]    rd_addr;
   logic [31:0]         key_rd;
   logic                key_ok_ff;
   logic [31:0]         key_word;
   logic                accept;
   logic                wr_en;
   logic [5:0]          key_index;
   logic [31:0]         new_col;
   logic [31:0]         sub_col;
   logic [31:0]         mix_col;
   logic                last_col;
   logic                stall;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign key_index  = req_tdata[5:0];
   assign wr_en      = accept && (req_tuser == ACT_KEY_WRITE)
                       && ({26'd0, key_index} < SCHEDULE_WORDS);

   // Word address read for the column that is processed in the next cycle.
   // The store read is registered, so the address runs one column ahead.
   // While the last column is held, the same word is read again.
   always_comb begin
      logic [RoundW-1:0] nr;
      logic [1:0]        nc;
      nr = round_ff;
      nc = col_ff;
      if (state_ff != ST_RUN) begin
         nr = '0;
         nc = 2'd0;
      end else if (!stall) begin
         nc = col_ff + 2'd1;
         if (col_ff == 2'd3) begin
            nr = round_ff + 1'b1;
         end
      end
      rd_idx = {nr, nc};
   end

   assign rd_addr = rd_idx[AddrW-1:0];

   aesbe_ram #(
      .Width(32),
      .Depth(SCHEDULE_WORDS)
   ) u_key_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(key_index[AddrW-1:0]),
      .wr_data(req_tdata[37:6]),
      .rd_addr(rd_addr),
      .rd_data(key_rd)
   );

   assign key_word = key_ok_ff ? key_rd : 32'd0;

   // ShiftRows: output column c takes row r from column c+r. The shift
   // register rotates so that column c sits at slot 0; column c+r is slot r.
   // Columns already rewritten this round were moved to the tail, so the
   // original bytes stay in the slots; the rewritten ones go to nxt_ff.
   logic [7:0] sb [4];
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         sb[r] = SBOX[cols_ff[r][31-8*r -: 8]];
      end
      sub_col = {sb[0], sb[1], sb[2], sb[3]};
      mix_col[31:24] = xtime(sb[0]) ^ gf_mul(sb[1], 8'h03) ^ sb[2] ^ sb[3];
      mix_col[23:16] = sb[0] ^ xtime(sb[1]) ^ gf_mul(sb[2], 8'h03) ^ sb[3];
      mix_col[15:8]  = sb[0] ^ sb[1] ^ xtime(sb[2]) ^ gf_mul(sb[3], 8'h03);
      mix_col[7:0]   = gf_mul(sb[0], 8'h03) ^ sb[1] ^ sb[2] ^ xtime(sb[3]);
      if (round_ff == '0) begin
         new_col = cols_ff[0] ^ key_word;
      end else if (round_ff == RoundW'(ROUNDS)) begin
         new_col = sub_col ^ key_word;
      end else begin
         new_col = mix_col ^ key_word;
      end
   end

   assign last_col = (col_ff == 2'd3) && (round_ff == RoundW'(ROUNDS));

   // The finished block cannot leave while the previous result still sits
   // in the output register and is not taken at this edge.
   assign stall = (state_ff == ST_RUN) && last_col && rsp_valid_ff && !rsp_tready;

   // Within a round the state is kept in a staging view: slots hold the
   // original columns c, c+1, c+2, c+3; the finished column leaves slot 0
   // into a separate result shift line that becomes the next round's state.
   logic [31:0] nxt_ff [4];

   always_ff @(posedge clock) begin
      key_ok_ff <= ({{(32-RoundW-2){1'b0}}, rd_idx} < 32'(SCHEDULE_WORDS));
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         round_ff     <= '0;
         col_ff       <= 2'd0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && (req_tuser == ACT_ENCRYPT)) begin
                  state_ff <= ST_PRIME;
                  round_ff <= '0;
                  col_ff   <= 2'd0;
               end
            end
            ST_PRIME: begin
               state_ff <= ST_RUN;
            end
            ST_RUN: begin
               if (!stall) begin
                  col_ff <= col_ff + 2'd1;
                  if (col_ff == 2'd3) begin
                     round_ff <= round_ff + 1'b1;
                  end
                  if (last_col) begin
                     state_ff     <= ST_IDLE;
                     rsp_valid_ff <= 1'b1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
      if (accept && (req_tuser == ACT_ENCRYPT)) begin
         for (int c = 0; c < 4; c++) begin
            cols_ff[c] <= (c < 2) ? req_tdata[101-32*c -: 32]
                                  : req_tdata[165-32*(c-2) -: 32];
         end
      end else if ((state_ff == ST_RUN) && !stall) begin
         // rotate the original columns; round 0 uses no row shift
         cols_ff[0] <= cols_ff[1];
         cols_ff[1] <= cols_ff[2];
         cols_ff[2] <= cols_ff[3];
         cols_ff[3] <= cols_ff[0];
         nxt_ff[0]  <= nxt_ff[1];
         nxt_ff[1]  <= nxt_ff[2];
         nxt_ff[2]  <= nxt_ff[3];
         nxt_ff[3]  <= new_col;
         if (col_ff == 2'd3) begin
            cols_ff[0] <= nxt_ff[1];
            cols_ff[1] <= nxt_ff[2];
            cols_ff[2] <= nxt_ff[3];
            cols_ff[3] <= new_col;
         end
         if (last_col) begin
            rsp_data_ff <= {nxt_ff[3], new_col, nxt_ff[1], nxt_ff[2]};
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready)
      else $error("request taken while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("result lost under stall");
   a_done_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && last_col) |=> rsp_valid_ff)
      else $error("finished block gave no result");
`endif

endmodule

// ----- src/aesbe_ram.sv -----
// ----------------------------------------------------------------------------
// AES block encryption generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module aesbe_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
